>>> design/idm_pkg.sv
// ============================================================================
// idm_pkg
// Shared types and codes for the floor divide / modulo pipeline.
// ============================================================================
`default_nettype none

package idm_pkg;

    localparam int DATA_W = 64;

    // opcode
    localparam logic OP_QUO = 1'b0;
    localparam logic OP_MOD = 1'b1;

    // width select
    localparam logic [1:0] WS_16 = 2'd0;
    localparam logic [1:0] WS_32 = 2'd1;
    localparam logic [1:0] WS_64 = 2'd2;

    // status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic [1:0]               width_select;
        logic signed [DATA_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor;
    } idm_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [1:0]               status;
    } idm_out_t;

    // word handed from cell to cell
    typedef struct packed {
        logic              opcode;
        logic              nneg;
        logic              dneg;
        logic [1:0]        status;
        logic [DATA_W-1:0] ud;    // |divisor|
        logic [DATA_W-1:0] rem;   // partial remainder
        logic [DATA_W-1:0] nq;    // dividend bits out, quotient bits in
    } idm_work_t;

endpackage

`default_nettype wire

>>> design/idm_prep.sv
// ============================================================================
// idm_prep
// Front stage: sign extension, special-case status, operand magnitudes.
// ============================================================================
`default_nettype none

module idm_prep
    import idm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire idm_in_t   in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output idm_work_t      out_data
);

    logic      valid_reg, valid_next;
    idm_work_t data_reg, data_next;

    logic [DATA_W-1:0] n, d;
    logic              n_is_min;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        case (in_data.width_select)
            WS_16: begin
                n        = {{48{in_data.dividend[15]}}, in_data.dividend[15:0]};
                d        = {{48{in_data.divisor[15]}}, in_data.divisor[15:0]};
                n_is_min = (n == {{49{1'b1}}, 15'd0});
            end
            WS_32: begin
                n        = {{32{in_data.dividend[31]}}, in_data.dividend[31:0]};
                d        = {{32{in_data.divisor[31]}}, in_data.divisor[31:0]};
                n_is_min = (n == {{33{1'b1}}, 31'd0});
            end
            default: begin
                n        = in_data.dividend;
                d        = in_data.divisor;
                n_is_min = (n == {1'b1, {(DATA_W-1){1'b0}}});
            end
        endcase
    end

    always_comb begin
        data_next.opcode = in_data.opcode;
        data_next.nneg   = n[DATA_W-1];
        data_next.dneg   = d[DATA_W-1];
        data_next.ud     = d[DATA_W-1] ? (DATA_W'(0) - d) : d;
        data_next.rem    = '0;
        data_next.nq     = n[DATA_W-1] ? (DATA_W'(0) - n) : n;
        if (d == '0) begin
            data_next.status = ST_DIV_ZERO;
        end else if ((&d) && (in_data.opcode == OP_QUO) && n_is_min) begin
            data_next.status = ST_RANGE;
        end else begin
            data_next.status = ST_OK;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> design/idm_cell.sv
// ============================================================================
// idm_cell
// One restoring division step: shift in a dividend bit, trial subtract,
// shift in one quotient bit.
// ============================================================================
`default_nettype none

module idm_cell
    import idm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire idm_work_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output idm_work_t      out_data
);

    logic      valid_reg, valid_next;
    idm_work_t data_reg, data_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] diff;
    logic              qbit;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rem_sh = {in_data.rem, in_data.nq[DATA_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, in_data.ud};
        qbit   = !diff[DATA_W+1];

        data_next     = in_data;
        data_next.rem = qbit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        data_next.nq  = {in_data.nq[DATA_W-2:0], qbit};
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> design/idm_post.sv
// ============================================================================
// idm_post
// Back stage: floor correction of truncated quotient and remainder, sign
// fix-up, status override. Doubles as the output register.
// ============================================================================
`default_nettype none

module idm_post
    import idm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire idm_work_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output idm_out_t       out_data
);

    logic     valid_reg, valid_next;
    idm_out_t data_reg, data_next;

    logic              differ, tr_nz;
    logic [DATA_W-1:0] q, r;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        differ = in_data.nneg ^ in_data.dneg;
        tr_nz  = (in_data.rem != '0);

        // -(tq + 1) == ~tq
        if (differ) begin
            q = tr_nz ? ~in_data.nq : (DATA_W'(0) - in_data.nq);
        end else begin
            q = in_data.nq;
        end

        if (differ && tr_nz) begin
            r = in_data.dneg ? (in_data.rem - in_data.ud) : (in_data.ud - in_data.rem);
        end else begin
            r = in_data.dneg ? (DATA_W'(0) - in_data.rem) : in_data.rem;
        end

        data_next.status = in_data.status;
        if (in_data.status != ST_OK) begin
            data_next.result = '0;
        end else if (in_data.opcode == OP_MOD) begin
            data_next.result = r;
        end else begin
            data_next.result = q;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> design/integer_floor_divmod.sv
// ============================================================================
// integer_floor_divmod
// Pipelined signed floor division / floor modulo, 16, 32 or 64 bit operands.
// ============================================================================
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+----------------------------------------
//  s_      | in  | s_valid / s_ready   | opcode, width_select, dividend, divisor
//  m_      | out | m_valid / m_ready   | result, status
//
//  One word accepted per cycle, sustained, while m_ready stays high. The pipe
//  is one prep stage, a row of 64 divide cells (one quotient bit each), one
//  fix-up stage that also holds the output word.
//  Each stage has its own valid bit and takes a new word when it is empty or
//  its word moves on, so a stall at m_ready backs up one stage at a time and
//  bubbles in the row are squeezed out; s_ready drops only once every stage
//  is full.
//  Reset clears the valid bits only; payload registers are not reset.
//
// ============================================================================
`default_nettype none

module integer_floor_divmod
    import idm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire idm_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output idm_out_t     m_data
);

    // stage 0 is the prep output, stage k (k >= 1) the output of cell k-1
    idm_work_t work  [DATA_W+1];
    logic      valid [DATA_W+1];
    logic      ready [DATA_W+1];

    idm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_data  (work[0])
    );

    // row of divide cells, MSB of the quotient first
    for (genvar i = 0; i < DATA_W; i++) begin : g_cell
        idm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .in_data   (work[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .out_data  (work[i+1])
        );
    end

    // floor correction and output register
    idm_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid[DATA_W]),
        .in_ready  (ready[DATA_W]),
        .in_data   (work[DATA_W]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

>>> design/idm_checker.sv
// ============================================================================
// idm_checker
// Port-level checks on the result channel of integer_floor_divmod.
// ============================================================================
`default_nettype none

module idm_checker
    import idm_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire idm_out_t m_data
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    // error status always carries a zero result
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> (m_data.result == '0))
        else $error("nonzero result with error status");

    // only defined status codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK) || (m_data.status == ST_DIV_ZERO)
                    || (m_data.status == ST_RANGE))
        else $error("undefined status code");

endmodule

bind integer_floor_divmod idm_checker u_idm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: integer_floor_divmod testbench
// Drives operand words through the valid/ready input channel with random
// gaps, back-pressures the result channel at random, predicts each floor
// quotient / floor modulo word and checks results in order.
// ----------------------------------------------------------------------------

module tb_top;

    import idm_pkg::*;

    // width select 3 is not named in the package; the block treats it as 64 bit
    localparam logic [1:0] WS_64_ALT = 2'd3;

    localparam int          RANDOM_WORDS = 1930;
    localparam int          DRAIN_CYCLES = 80;    // wait after the scoreboard empties
    localparam int          HOLD_CYCLES  = 400;   // long m_ready hold-off
    localparam int          HOLD_AFTER   = 300;   // results seen before it
    localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no handshake

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each result when its operand word is accepted and
    // matches results against the oldest prediction.
    // ------------------------------------------------------------------------
    class divmod_scoreboard;
        idm_out_t    due[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // take the low bits of the selected width and sign-extend them
        function logic [63:0] narrow(logic [63:0] raw, logic [63:0] mask);
            logic [63:0] v;
            v = raw & mask;
            if ((v & ((mask >> 1) + 64'd1)) != 64'd0) v = v | ~mask;
            return v;
        endfunction

        function idm_out_t floor_divmod(idm_in_t w);
            logic [63:0] mask, n, d, lowest, un, ud, tq, tr, q, r;
            logic        nneg, dneg;
            idm_out_t    o;
            case (w.width_select)
                WS_16:   mask = 64'h0000_0000_0000_FFFF;
                WS_32:   mask = 64'h0000_0000_FFFF_FFFF;
                default: mask = MINUS_ONE;
            endcase
            n      = narrow(w.dividend, mask);
            d      = narrow(w.divisor, mask);
            lowest = ~(mask >> 1);
            o.result = '0;
            o.status = ST_OK;
            if (d == 64'd0) begin
                o.status = ST_DIV_ZERO;
            end else if (d == MINUS_ONE) begin
                // modulo by -1 stays 0; quotient negates unless it overflows
                if (w.opcode == OP_QUO) begin
                    if (n == lowest) o.status = ST_RANGE;
                    else o.result = 64'd0 - n;
                end
            end else begin
                nneg = n[63];
                dneg = d[63];
                un   = nneg ? 64'd0 - n : n;
                ud   = dneg ? 64'd0 - d : d;
                tq   = un / ud;
                tr   = un % ud;
                if (nneg != dneg) begin
                    // truncated quotient rounds up for mixed signs; step down
                    if (tr != 64'd0) begin
                        q = 64'd0 - (tq + 64'd1);
                        r = ud - tr;
                    end else begin
                        q = 64'd0 - tq;
                        r = 64'd0;
                    end
                end else begin
                    q = tq;
                    r = tr;
                end
                if (dneg) r = 64'd0 - r;
                o.result = (w.opcode == OP_QUO) ? q : r;
            end
            return o;
        endfunction

        function void note_operands(idm_in_t w);
            due.push_back(floor_divmod(w));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns: result word %0d, %s: got %h, want %h",
                     $realtime, checked, what, got, want);
            mismatches++;
        endtask

        task check_result(idm_out_t got);
            idm_out_t want;
            if (due.size() == 0) begin
                report("no word pending", got.result, 64'd0);
            end else begin
                want = due.pop_front();
                if (got.result !== want.result)
                    report("result", got.result, want.result);
                if (got.status !== want.status)
                    report("status", 64'(got.status), 64'(want.status));
            end
            checked++;
        endtask
    endclass

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    idm_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    idm_out_t m_data;

    divmod_scoreboard sb = new();

    int unsigned idle_cycles = 0;
    int unsigned tx_gap_max  = 5;
    int          sent        = 0;

    integer_floor_divmod uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog. Sampled at the rising edge, before the block's
    // own registers update, so handshakes are seen as the block sees them.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_operands(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("integer_floor_divmod: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after the
    // word is taken. Valid drops only for a drawn gap, never between words
    // that go back to back.
    // ------------------------------------------------------------------------
    task send_word(input logic op, input logic [1:0] ws,
                   input logic [63:0] n, input logic [63:0] d);
        int unsigned gap;
        // every 50 words, pick a burst mode or a gappy one
        if (sent % 50 == 0) tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_data.opcode       <= op;
        s_data.width_select <= ws;
        s_data.dividend     <= n;
        s_data.divisor      <= d;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    // operand with a spread of magnitudes, extremes and junk upper bits
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        int          s;
        case ($urandom_range(0, 7))
            0, 1: v = {$urandom, $urandom};
            2, 3: begin
                v = {$urandom, $urandom} >> $urandom_range(1, 63);
                if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
            end
            4, 5: begin
                s = $urandom_range(0, 40);
                s = s - 20;
                v = 64'(signed'(s));
            end
            default: begin
                case ($urandom_range(0, 9))
                    0: v = MIN64;
                    1: v = MAX64;
                    2: v = MINUS_ONE;
                    3: v = 64'd0;
                    4: v = 64'd1;
                    5: v = 64'hFFFF_FFFF_FFFF_8000;   // 16-bit minimum
                    6: v = 64'h0000_0000_0000_7FFF;
                    7: v = 64'hFFFF_FFFF_8000_0000;   // 32-bit minimum
                    8: v = 64'h0000_0000_7FFF_FFFF;
                    default: v = {$urandom, 16'h0000, 16'h8000};
                endcase
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: per result draws a random hold-off up to rx_gap_max; once, after
    // HOLD_AFTER results, holds m_ready low long enough to fill the pipe
    // and push back on s_ready.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned gap, rx_gap_max, taken;
        logic        held;
        rx_gap_max = 5;
        taken      = 0;
        held       = 1'b0;
        m_ready    = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (taken % 50 == 0) rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            gap = $urandom_range(0, rx_gap_max);
            if (!held && taken >= HOLD_AFTER) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed words, random words, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic        op;
        logic [1:0]  ws;
        logic [63:0] n, d;
        int          k;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sign combinations, with and without a remainder
        send_word(OP_QUO, WS_64, 64'd7, 64'd0 - 64'd2);
        send_word(OP_MOD, WS_64, 64'd7, 64'd0 - 64'd2);
        send_word(OP_QUO, WS_32, 64'd0 - 64'd7, 64'd2);
        send_word(OP_MOD, WS_32, 64'd0 - 64'd7, 64'd2);
        send_word(OP_QUO, WS_16, 64'd0 - 64'd7, 64'd0 - 64'd2);
        send_word(OP_MOD, WS_16, 64'd0 - 64'd7, 64'd0 - 64'd2);
        send_word(OP_QUO, WS_64, 64'd0 - 64'd8, 64'd2);
        send_word(OP_MOD, WS_64, 64'd0 - 64'd8, 64'd2);
        // zero divisor, both operations
        send_word(OP_QUO, WS_16, 64'd5, 64'd0);
        send_word(OP_MOD, WS_64, 64'd5, 64'd0);
        // minimum by -1 at each width; junk above the 16-bit operands
        send_word(OP_QUO, WS_16, 64'hABCD_0000_1234_8000, 64'h5555_0000_0000_FFFF);
        send_word(OP_QUO, WS_32, 64'h0000_0000_8000_0000, MINUS_ONE);
        send_word(OP_QUO, WS_64, MIN64, MINUS_ONE);
        send_word(OP_QUO, WS_64_ALT, MIN64, MINUS_ONE);
        // modulo by -1 is 0, quotient by -1 negates
        send_word(OP_MOD, WS_64, MIN64, MINUS_ONE);
        send_word(OP_QUO, WS_32, 64'd123, MINUS_ONE);
        // extremes
        send_word(OP_QUO, WS_64, MAX64, MIN64);
        send_word(OP_MOD, WS_64, MAX64, MIN64);
        send_word(OP_QUO, WS_64, MIN64, 64'd1);
        send_word(OP_MOD, WS_64, MIN64, MAX64);
        send_word(OP_QUO, WS_16, 64'h0000_0000_0000_7FFF, 64'd1);
        send_word(OP_MOD, WS_32, 64'd0, 64'd7);
        // 0xFFFF reads as -1 in 16 bits; divisor's bit 16 is ignored
        send_word(OP_QUO, WS_16, 64'h0000_0000_0000_FFFF, 64'h0000_0000_0001_0002);

        for (k = 0; k < RANDOM_WORDS; k++) begin
            op = 1'($urandom_range(0, 1));
            ws = ($urandom_range(0, 15) == 15) ? WS_64_ALT : 2'($urandom_range(0, 2));
            d  = pick_operand();
            n  = pick_operand();
            // exact multiples now and then, to hit zero remainders
            if ($urandom_range(0, 7) == 0) n = d * pick_operand();
            send_word(op, ws, n, d);
        end
        s_valid <= 1'b0;

        while (sb.due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("integer_floor_divmod: match");
        end else begin
            $display("integer_floor_divmod: mismatch");
        end
        $finish;
    end

endmodule
